/* src/tbmcq_pkg.sv */
// ----------------------------------------------------------------------------
// tbmcq_pkg
// Shared types and constants for the trackball motion and click qualifier.
// ----------------------------------------------------------------------------
package tbmcq_pkg;

   localparam logic [15:0] CLICK_LIMIT_RESET = 16'd400;
   localparam logic [15:0] HOLD_MAX          = 16'hFFFF;
   localparam logic signed [15:0] STEP_MAX   = 16'sh7FFF;
   localparam logic signed [15:0] STEP_MIN   = -16'sh8000;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_PULSE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } direction_type;

   typedef struct packed {
      logic [1:0] action;
      logic       click_pin_low;
      logic [1:0] direction;
      logic       key_locked;
   } req_type;

   typedef struct packed {
      logic signed [15:0] step_diff;
      logic               click_pressed;
      logic               moved_seen;
      logic [15:0]        hold_ms;
   } rsp_type;

endpackage

/* src/trackball_motion_and_click_qualifier.sv */
// ----------------------------------------------------------------------------
// trackball_motion_and_click_qualifier
// Counts vertical trackball steps, tracks motion and qualifies short clicks.
// ----------------------------------------------------------------------------
// Path: request register, then result register; rsp_stall holds the result
//   and, through req_stall, the request behind it.
// Throughput: one request per cycle unless rsp_stall holds a result; a new
//   request enters only while the request register is empty or advancing.
// Reset: synchronous; all but data registers cleared; limit back to 400 ms.
// ----------------------------------------------------------------------------
module trackball_motion_and_click_qualifier
   import tbmcq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic        req_valid_ff, req_valid_in;
   req_type     req_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [15:0] limit_ff;

   logic signed [15:0] vcount_ff, vcount_in;
   logic        moved_ff, moved_in;
   logic        rel_seen_ff, rel_seen_in;
   logic        press_ff, press_in;
   logic [15:0] hold_ff, hold_in;
   logic [15:0] hold_inc;
   logic        pending_ff, pending_in;

   logic        accept;
   logic        advance;

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign hold_inc = (press_ff && hold_ff != HOLD_MAX) ? hold_ff + 16'd1 : hold_ff;

   always_comb begin
      vcount_in   = vcount_ff;
      moved_in    = moved_ff;
      rel_seen_in = rel_seen_ff;
      press_in    = press_ff;
      hold_in     = hold_ff;
      pending_in  = pending_ff;
      rsp_in      = '0;
      unique case (action_type'(req_ff.action))
         ACT_TICK: begin
            hold_in = hold_inc;
            if (!rel_seen_ff) begin
               if (!req_ff.click_pin_low) rel_seen_in = 1'b1;
            end else if (req_ff.click_pin_low && !press_ff) begin
               press_in = 1'b1;
               hold_in  = '0;
            end else if (!req_ff.click_pin_low && press_ff) begin
               press_in = 1'b0;
               if (hold_inc < limit_ff) pending_in = 1'b1;
               hold_in = '0;
            end
         end
         ACT_PULSE: begin
            moved_in = 1'b1;
            if (direction_type'(req_ff.direction) == DIR_UP) begin
               if (vcount_ff != STEP_MIN) vcount_in = vcount_ff - 16'sd1;
            end else if (direction_type'(req_ff.direction) == DIR_DOWN) begin
               if (vcount_ff != STEP_MAX) vcount_in = vcount_ff + 16'sd1;
            end
         end
         ACT_READ: begin
            vcount_in  = '0;
            pending_in = 1'b0;
            if (!req_ff.key_locked) begin
               rsp_in.step_diff     = vcount_ff;
               rsp_in.click_pressed = pending_ff;
            end
         end
         ACT_QUERY: begin
            rsp_in.moved_seen = moved_ff;
            moved_in          = 1'b0;
         end
         default: ;
      endcase
      rsp_in.hold_ms = press_in ? hold_in : '0;
   end

   always_comb begin
      req_valid_in = req_valid_ff;
      if (accept)       req_valid_in = 1'b1;
      else if (advance) req_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (advance)        rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      if (advance) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= CLICK_LIMIT_RESET;
         vcount_ff    <= '0;
         moved_ff     <= 1'b0;
         rel_seen_ff  <= 1'b0;
         press_ff     <= 1'b0;
         hold_ff      <= '0;
         pending_ff   <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) limit_ff <= csr_wdata;
         if (advance) begin
            vcount_ff   <= vcount_in;
            moved_ff    <= moved_in;
            rel_seen_ff <= rel_seen_in;
            press_ff    <= press_in;
            hold_ff     <= hold_in;
            pending_ff  <= pending_in;
         end
      end
   end

   a_stall_needs_request: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |-> !req_stall)
      else $error("stall raised with empty request register");

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed request produced no result");

   a_idle_hold_zero: assert property (@(posedge clock) disable iff (reset)
      !press_ff |-> hold_ff == '0)
      else $error("hold timer running without a press");

   a_press_after_release: assert property (@(posedge clock) disable iff (reset)
      !rel_seen_ff |-> !press_ff)
      else $error("press accepted before first release");

   a_read_clears_click: assert property (@(posedge clock) disable iff (reset)
      advance && action_type'(req_ff.action) == ACT_READ |=> !pending_ff)
      else $error("pending click survived a read");

endmodule
